>>> design/ccp_pkg.sv
// shared types and constants for the cable constraint projection core
// no dependencies; imported by the top level core and the testbench
package ccp_pkg;

   localparam int COORD_W  = 32;              // Q16.16 coordinate
   localparam int MASS_W   = 32;              // Q16.16 inverse mass
   localparam int LEN_W    = 31;              // cable length register
   localparam int DIFF_W   = COORD_W + 1;     // per-axis difference / magnitude
   localparam int SQ_W     = 2 * DIFF_W - 1;  // square of a magnitude up to 2^32
   localparam int SUM_W    = SQ_W + 1;        // sum of three squares
   localparam int ROOT_W   = 34;              // floor(sqrt) of the sum
   localparam int RAD_W    = 2 * ROOT_W;      // radicand as seen by the root unit
   localparam int DEN_W    = MASS_W + 1;      // ia + ib
   localparam int SPROD_W  = ROOT_W + MASS_W; // excess times one inverse mass
   localparam int CPROD_W  = DIFF_W + ROOT_W; // magnitude times share
   localparam int AXES     = 3;

   // how the excess is split between the two bodies
   typedef enum logic [1:0] {
      MODE_PARTICLE = 2'd0,  // particle takes all of it
      MODE_ANCHOR   = 2'd1,  // anchor takes all of it
      MODE_SPLIT    = 2'd2   // shared by inverse mass
   } mode_type;

   // carried alongside the root unit
   typedef struct packed {
      logic                              is_point;
      logic [MASS_W-1:0]                 ia;
      logic [MASS_W-1:0]                 ib;
      logic [AXES-1:0]                   neg;
      logic [AXES-1:0][DIFF_W-1:0]       mag;
   } geom_type;

   // carried alongside the share divider
   typedef struct packed {
      logic                              taut;
      mode_type                          mode;
      logic [ROOT_W-1:0]                 e;
      logic [ROOT_W-1:0]                 n;
      logic [AXES-1:0]                   neg;
      logic [AXES-1:0][DIFF_W-1:0]       mag;
   } share_side_type;

   // carried alongside the component divider
   typedef struct packed {
      logic                              taut;
      logic [AXES-1:0]                   neg;
   } comp_side_type;

   // one result word
   typedef struct packed {
      logic                              taut;
      logic [AXES-1:0][COORD_W-1:0]      anchor_d;
      logic [AXES-1:0][COORD_W-1:0]      particle_d;
   } result_type;

endpackage

>>> design/ccp_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage
// depends on nothing but its parameters; sideband word travels with each root
module ccp_sqrt_pipe #(
   parameter int ROOT_W = 34,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [ROOT_W-1:0] valid_ff, valid_in;
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_in  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic [SIDE_W-1:0] side_in [ROOT_W];

   // one digit pair per stage: bring down two bits, try root*4+1
   always_comb begin
      logic              src_valid;
      logic [RAD_W-1:0]  src_rad;
      logic [REM_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [SIDE_W-1:0] src_side;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  test;
      logic              ge;
      for (int s = 0; s < ROOT_W; s++) begin
         if (s == 0) begin
            src_valid = in_valid;
            src_rad   = in_rad;
            src_rem   = '0;
            src_root  = '0;
            src_side  = in_side;
         end else begin
            src_valid = valid_ff[s-1];
            src_rad   = rad_ff[s-1];
            src_rem   = rem_ff[s-1];
            src_root  = root_ff[s-1];
            src_side  = side_ff[s-1];
         end
         trial = {src_rem, src_rad[RAD_W-1 -: 2]};
         test  = {(REM_W)'(src_root), 2'b01};
         ge    = (trial >= test);
         valid_in[s] = src_valid;
         rad_in[s]   = {src_rad[RAD_W-3:0], 2'b00};
         rem_in[s]   = ge ? REM_W'(trial - test) : REM_W'(trial);
         root_in[s]  = {src_root[ROOT_W-2:0], ge};
         side_in[s]  = src_side;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

>>> design/ccp_div_pipe.sv
// pipelined restoring divider, several dividends over one shared divisor
// one quotient bit per stage; the quotient must fit in QUOT_W bits
module ccp_div_pipe #(
   parameter int LANES  = 2,
   parameter int NUM_W  = 66,
   parameter int DEN_W  = 33,
   parameter int QUOT_W = 34,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [NUM_W-1:0]      in_num [LANES],
   input  logic [DEN_W-1:0]      in_den,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [QUOT_W-1:0]     out_quot [LANES],
   output logic [SIDE_W-1:0]     out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;

   logic [QUOT_W-1:0] valid_ff, valid_in;
   logic [NUM_W-1:0]  rem_ff  [QUOT_W][LANES];
   logic [NUM_W-1:0]  rem_in  [QUOT_W][LANES];
   logic [QUOT_W-1:0] quot_ff [QUOT_W][LANES];
   logic [QUOT_W-1:0] quot_in [QUOT_W][LANES];
   logic [DEN_W-1:0]  den_ff  [QUOT_W];
   logic [DEN_W-1:0]  den_in  [QUOT_W];
   logic [SIDE_W-1:0] side_ff [QUOT_W];
   logic [SIDE_W-1:0] side_in [QUOT_W];

   // stage s decides quotient bit QUOT_W-1-s
   always_comb begin
      logic              src_valid;
      logic [DEN_W-1:0]  src_den;
      logic [SIDE_W-1:0] src_side;
      logic [NUM_W-1:0]  src_rem;
      logic [QUOT_W-1:0] src_quot;
      logic [CMP_W-1:0]  shifted;
      logic [CMP_W-1:0]  ext;
      logic              ge;
      for (int s = 0; s < QUOT_W; s++) begin
         if (s == 0) begin
            src_valid = in_valid;
            src_den   = in_den;
            src_side  = in_side;
         end else begin
            src_valid = valid_ff[s-1];
            src_den   = den_ff[s-1];
            src_side  = side_ff[s-1];
         end
         valid_in[s] = src_valid;
         den_in[s]   = src_den;
         side_in[s]  = src_side;
         shifted     = CMP_W'(src_den) << (QUOT_W - 1 - s);
         for (int l = 0; l < LANES; l++) begin
            if (s == 0) begin
               src_rem  = in_num[l];
               src_quot = '0;
            end else begin
               src_rem  = rem_ff[s-1][l];
               src_quot = quot_ff[s-1][l];
            end
            ext = CMP_W'(src_rem);
            ge  = (ext >= shifted);
            rem_in[s][l]  = ge ? NUM_W'(ext - shifted) : src_rem;
            quot_in[s][l] = {src_quot[QUOT_W-2:0], ge};
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

>>> design/cable_constraint_projection_core.sv
// top level of the cable constraint projection core
// depends on ccp_pkg, ccp_sqrt_pipe and ccp_div_pipe
//
// Takes one constraint word per cycle while req_stall is low and returns one
// displacement word per constraint, in order. It is built from three
// bit-per-stage units in a row: the 34-stage square root for the distance,
// the 34-stage divider that splits the excess by inverse mass, and the
// 34-stage divider that projects the share onto each axis, plus the difference,
// square, sum, excess, multiply, share-pick and saturating output stages.
// A full pipeline sustains one word per clock while rsp_stall is low; a stall on
// the result side is absorbed by a one-word skid stage before req_stall is raised.
// csr_cable_length may be written at any time the core holds no words.
module cable_constraint_projection_core (
   input  logic                          clock,
   input  logic                          reset,
   // constraint words
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_anchor_is_point,
   input  logic signed [31:0]            req_anchor_x,
   input  logic signed [31:0]            req_anchor_y,
   input  logic signed [31:0]            req_anchor_z,
   input  logic [31:0]                   req_anchor_inv_mass,
   input  logic signed [31:0]            req_particle_x,
   input  logic signed [31:0]            req_particle_y,
   input  logic signed [31:0]            req_particle_z,
   input  logic [31:0]                   req_particle_inv_mass,
   // displacement words
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_taut,
   output logic signed [31:0]            rsp_anchor_dx,
   output logic signed [31:0]            rsp_anchor_dy,
   output logic signed [31:0]            rsp_anchor_dz,
   output logic signed [31:0]            rsp_particle_dx,
   output logic signed [31:0]            rsp_particle_dy,
   output logic signed [31:0]            rsp_particle_dz,
   // cable length register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ccp_pkg::LEN_W-1:0]     csr_cable_length
);

   import ccp_pkg::*;

   logic en;

   // cable length register
   logic [LEN_W-1:0] length_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(65536);
      end else if (csr_valid && csr_ready) begin
         length_ff <= csr_cable_length;
      end
   end

   // stage 1: per-axis difference, split into sign and magnitude
   logic [AXES-1:0][COORD_W-1:0] apos, ppos;
   logic                         v1_ff;
   geom_type                     g1_ff, g1_in;
   assign apos = {req_anchor_z, req_anchor_y, req_anchor_x};
   assign ppos = {req_particle_z, req_particle_y, req_particle_x};

   always_comb begin
      logic [DIFF_W-1:0] diff;
      g1_in.is_point = req_anchor_is_point;
      g1_in.ia       = req_anchor_inv_mass;
      g1_in.ib       = req_particle_inv_mass;
      for (int k = 0; k < AXES; k++) begin
         diff = {apos[k][COORD_W-1], apos[k]} - {ppos[k][COORD_W-1], ppos[k]};
         g1_in.neg[k] = diff[DIFF_W-1];
         g1_in.mag[k] = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      end
   end

   // stage 2: squares
   logic                         v2_ff;
   geom_type                     g2_ff;
   logic [SQ_W-1:0]              sq_ff [AXES];

   // stage 3: sum of squares
   logic                         v3_ff;
   geom_type                     g3_ff;
   logic [SUM_W-1:0]             sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g1_ff <= g1_in;
         g2_ff <= g1_ff;
         for (int k = 0; k < AXES; k++) begin
            sq_ff[k] <= SQ_W'(g1_ff.mag[k]) * SQ_W'(g1_ff.mag[k]);
         end
         g3_ff  <= g2_ff;
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      end
   end

   // distance
   logic                sq_valid;
   logic [ROOT_W-1:0]   sq_root;
   logic [$bits(geom_type)-1:0] sq_side;
   geom_type            gs;

   ccp_sqrt_pipe #(
      .ROOT_W (ROOT_W),
      .SIDE_W ($bits(geom_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (RAD_W'(sum_ff)),
      .in_side   (g3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );
   assign gs = geom_type'(sq_side);

   // stage 4: excess, split mode and mass sum
   logic               v4_ff;
   share_side_type     s4_ff, s4_in;
   logic [MASS_W-1:0]  ia4_ff, ib4_ff;
   logic [DEN_W-1:0]   den4_ff;

   always_comb begin
      s4_in.taut = (sq_root > ROOT_W'(length_ff));
      s4_in.e    = sq_root - ROOT_W'(length_ff);
      s4_in.n    = sq_root;
      s4_in.neg  = gs.neg;
      s4_in.mag  = gs.mag;
      if (gs.is_point || gs.ia == '0) begin
         s4_in.mode = MODE_PARTICLE;
      end else if (gs.ib == '0) begin
         s4_in.mode = MODE_ANCHOR;
      end else begin
         s4_in.mode = MODE_SPLIT;
      end
   end

   // stage 5: excess times each inverse mass
   logic               v5_ff;
   share_side_type     s5_ff;
   logic [DEN_W-1:0]   den5_ff;
   logic [SPROD_W-1:0] sprod_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= sq_valid;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff       <= s4_in;
         ia4_ff      <= gs.ia;
         ib4_ff      <= gs.ib;
         den4_ff     <= DEN_W'(gs.ia) + DEN_W'(gs.ib);
         s5_ff       <= s4_ff;
         den5_ff     <= den4_ff;
         sprod_ff[0] <= SPROD_W'(s4_ff.e) * SPROD_W'(ia4_ff);
         sprod_ff[1] <= SPROD_W'(s4_ff.e) * SPROD_W'(ib4_ff);
      end
   end

   // share of the excess for each body
   logic                  sd_valid;
   logic [ROOT_W-1:0]     sd_quot [2];
   logic [$bits(share_side_type)-1:0] sd_side;
   share_side_type        ss;

   ccp_div_pipe #(
      .LANES  (2),
      .NUM_W  (SPROD_W),
      .DEN_W  (DEN_W),
      .QUOT_W (ROOT_W),
      .SIDE_W ($bits(share_side_type))
   ) u_share_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_num    (sprod_ff),
      .in_den    (den5_ff),
      .in_side   (s5_ff),
      .out_valid (sd_valid),
      .out_quot  (sd_quot),
      .out_side  (sd_side)
   );
   assign ss = share_side_type'(sd_side);

   // stage 6: pick shares by mode
   logic                          v6_ff;
   logic [ROOT_W-1:0]             sa6_ff, sp6_ff, sa_in, sp_in;
   logic [ROOT_W-1:0]             n6_ff;
   logic [AXES-1:0][DIFF_W-1:0]   mag6_ff;
   comp_side_type                 c6_ff;

   always_comb begin
      case (ss.mode)
         MODE_PARTICLE: begin
            sa_in = '0;
            sp_in = ss.e;
         end
         MODE_ANCHOR: begin
            sa_in = ss.e;
            sp_in = '0;
         end
         MODE_SPLIT: begin
            sa_in = sd_quot[0];
            sp_in = sd_quot[1];
         end
         default: begin
            sa_in = '0;
            sp_in = '0;
         end
      endcase
   end

   // stage 7: magnitude times share per axis and body
   logic                 v7_ff;
   comp_side_type        c7_ff;
   logic [ROOT_W-1:0]    n7_ff;
   logic [CPROD_W-1:0]   cprod_ff [2*AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= sd_valid;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa6_ff     <= sa_in;
         sp6_ff     <= sp_in;
         n6_ff      <= ss.n;
         mag6_ff    <= ss.mag;
         c6_ff.taut <= ss.taut;
         c6_ff.neg  <= ss.neg;
         c7_ff      <= c6_ff;
         n7_ff      <= n6_ff;
         for (int k = 0; k < AXES; k++) begin
            cprod_ff[k]      <= CPROD_W'(mag6_ff[k]) * CPROD_W'(sa6_ff);
            cprod_ff[AXES+k] <= CPROD_W'(mag6_ff[k]) * CPROD_W'(sp6_ff);
         end
      end
   end

   // projection onto each axis
   logic                  cd_valid;
   logic [ROOT_W-1:0]     cd_quot [2*AXES];
   logic [$bits(comp_side_type)-1:0] cd_side;
   comp_side_type         cs;

   ccp_div_pipe #(
      .LANES  (2*AXES),
      .NUM_W  (CPROD_W),
      .DEN_W  (ROOT_W),
      .QUOT_W (ROOT_W),
      .SIDE_W ($bits(comp_side_type))
   ) u_comp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .in_num    (cprod_ff),
      .in_den    (n7_ff),
      .in_side   (c7_ff),
      .out_valid (cd_valid),
      .out_quot  (cd_quot),
      .out_side  (cd_side)
   );
   assign cs = comp_side_type'(cd_side);

   // signed saturation of a magnitude
   function automatic logic [COORD_W-1:0] sat_signed(input logic [ROOT_W-1:0] q,
                                                     input logic neg);
      logic [COORD_W-1:0] res;
      if (!neg) begin
         res = (q > ROOT_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[COORD_W-1:0];
      end else begin
         res = (q >= ROOT_W'(32'h8000_0000)) ? 32'h8000_0000
                                             : (~q[COORD_W-1:0] + 32'd1);
      end
      return res;
   endfunction

   // result word: anchor moves against d, particle along it
   result_type res;
   always_comb begin
      res.taut = cs.taut;
      for (int k = 0; k < AXES; k++) begin
         res.anchor_d[k]   = cs.taut ? sat_signed(cd_quot[k], !cs.neg[k]) : '0;
         res.particle_d[k] = cs.taut ? sat_signed(cd_quot[AXES+k], cs.neg[k]) : '0;
      end
   end

   // output register with one-word skid
   logic        rsp_valid_ff, skid_valid_ff, out_free;
   result_type  rsp_ff, skid_ff;

   assign en       = !skid_valid_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= cd_valid;
         end
      end else if (en && cd_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : res;
      end else if (en && cd_valid) begin
         skid_ff <= res;
      end
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_taut        = rsp_ff.taut;
   assign rsp_anchor_dx   = rsp_ff.anchor_d[0];
   assign rsp_anchor_dy   = rsp_ff.anchor_d[1];
   assign rsp_anchor_dz   = rsp_ff.anchor_d[2];
   assign rsp_particle_dx = rsp_ff.particle_d[0];
   assign rsp_particle_dy = rsp_ff.particle_d[1];
   assign rsp_particle_dz = rsp_ff.particle_d[2];

   // skid only fills behind a waiting output word
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a word while output register is empty");

   // skid fills only when the output side was stalled
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall))
      else $error("skid filled without output stall");

   // a slack cable moves nothing
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.taut) |-> (rsp_ff.anchor_d == '0 && rsp_ff.particle_d == '0))
      else $error("nonzero displacement on slack cable");

endmodule

>>> sim/tb.sv
// self-checking testbench for cable_constraint_projection_core
// depends on ccp_pkg and the core; holds its own Q16.16 projection predictor
`timescale 1ns / 1ps

// one constraint word as driven on the req_ ports
typedef struct {
   bit              is_point;
   bit signed [31:0] ax, ay, az;
   bit [31:0]       ia;
   bit signed [31:0] px, py, pz;
   bit [31:0]       ib;
} constraint_type;

class projection_scoreboard;
   bit [30:0] cable_length;
   ccp_pkg::result_type displacement_queue[$];
   int errors;

   function new();
      cable_length = 31'd65536;
      errors = 0;
   endfunction

   // clamp a signed value to the 32-bit output range
   function bit [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // expected displacement word for one constraint
   function ccp_pkg::result_type project(constraint_type w);
      ccp_pkg::result_type r;
      bit signed [32:0] d[3];
      bit [127:0] mag[3];
      bit [127:0] sum, rem, root, test, n, e, sa, sp;
      longint ca, cp;
      r = '0;
      sum = 0;
      d[0] = $signed({w.ax[31], w.ax}) - $signed({w.px[31], w.px});
      d[1] = $signed({w.ay[31], w.ay}) - $signed({w.py[31], w.py});
      d[2] = $signed({w.az[31], w.az}) - $signed({w.pz[31], w.pz});
      for (int k = 0; k < 3; k++) begin
         mag[k] = d[k][32] ? 128'(-d[k]) : 128'(d[k]);
         sum += mag[k] * mag[k];
      end
      // bitwise integer square root
      rem = 0;
      root = 0;
      for (int i = 33; i >= 0; i--) begin
         rem = (rem << 2) | ((sum >> (2 * i)) & 128'd3);
         test = (root << 2) | 128'd1;
         root = root << 1;
         if (rem >= test) begin
            rem -= test;
            root |= 128'd1;
         end
      end
      n = root;
      if (n <= 128'(cable_length)) return r;
      e = n - 128'(cable_length);
      sa = 0;
      sp = 0;
      // split of the excess between the bodies
      if (w.is_point || w.ia == 0) sp = e;
      else if (w.ib == 0) sa = e;
      else begin
         sa = (e * 128'(w.ia)) / (128'(w.ia) + 128'(w.ib));
         sp = (e * 128'(w.ib)) / (128'(w.ia) + 128'(w.ib));
      end
      r.taut = 1'b1;
      for (int k = 0; k < 3; k++) begin
         ca = longint'((mag[k] * sa) / n);
         cp = longint'((mag[k] * sp) / n);
         if (d[k][32]) cp = -cp;
         else ca = -ca;
         r.anchor_d[k] = clamp32(ca);
         r.particle_d[k] = clamp32(cp);
      end
      return r;
   endfunction

   function void note_constraint(constraint_type w);
      displacement_queue.push_back(project(w));
   endfunction

   function void check_displacement(ccp_pkg::result_type got);
      ccp_pkg::result_type want;
      if (displacement_queue.size() == 0) begin
         $display("%0t: unexpected displacement word %h", $time, got);
         errors++;
         return;
      end
      want = displacement_queue.pop_front();
      if (got.taut !== want.taut) begin
         $display("%0t: taut expected %0d actual %0d", $time, want.taut, got.taut);
         errors++;
      end
      for (int k = 0; k < 3; k++) begin
         if (got.anchor_d[k] !== want.anchor_d[k]) begin
            $display("%0t: anchor_d[%0d] expected %h actual %h", $time, k,
                     want.anchor_d[k], got.anchor_d[k]);
            errors++;
         end
         if (got.particle_d[k] !== want.particle_d[k]) begin
            $display("%0t: particle_d[%0d] expected %h actual %h", $time, k,
                     want.particle_d[k], got.particle_d[k]);
            errors++;
         end
      end
   endfunction
endclass

module tb;
   import ccp_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, req_anchor_is_point;
   logic signed [31:0] req_anchor_x, req_anchor_y, req_anchor_z;
   logic signed [31:0] req_particle_x, req_particle_y, req_particle_z;
   logic [31:0] req_anchor_inv_mass, req_particle_inv_mass;
   logic rsp_valid, rsp_stall, rsp_taut;
   logic signed [31:0] rsp_anchor_dx, rsp_anchor_dy, rsp_anchor_dz;
   logic signed [31:0] rsp_particle_dx, rsp_particle_dy, rsp_particle_dz;
   logic csr_valid, csr_ready;
   logic [LEN_W-1:0] csr_cable_length;

   projection_scoreboard sb;
   bit quiet;          // no idling on either side
   bit hold_request;   // ask the receiver for one long hold-off
   int long_hold;
   int short_hold;
   longint cycles;

   cable_constraint_projection_core i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 600000) begin
            $display("cable_constraint_projection_core regression: fail");
            $finish;
         end
      end
   end

   // result side: check each accepted word, then pick the next stall
   initial begin
      long_hold = 0;
      short_hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            result_type got;
            got.taut = rsp_taut;
            got.anchor_d = {rsp_anchor_dz, rsp_anchor_dy, rsp_anchor_dx};
            got.particle_d = {rsp_particle_dz, rsp_particle_dy, rsp_particle_dx};
            sb.check_displacement(got);
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 0;
            long_hold = 400;
            rsp_stall <= 1'b1;
         end else if (short_hold > 0) begin
            short_hold--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            if ($urandom_range(0, 99) < 3) short_hold = $urandom_range(10, 40);
            rsp_stall <= ($urandom_range(0, 99) < 25);
         end
      end
   end

   function int gap_length();
      if (quiet) return 0;
      if ($urandom_range(0, 99) < 4) return $urandom_range(10, 30);
      if ($urandom_range(0, 99) < 40) return $urandom_range(1, 3);
      return 0;
   endfunction

   // offer one word until accepted, with a random gap ahead of it
   task automatic send_word(constraint_type w);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_anchor_is_point <= w.is_point;
      req_anchor_x <= w.ax;
      req_anchor_y <= w.ay;
      req_anchor_z <= w.az;
      req_anchor_inv_mass <= w.ia;
      req_particle_x <= w.px;
      req_particle_y <= w.py;
      req_particle_z <= w.pz;
      req_particle_inv_mass <= w.ib;
      do @(posedge clock); while (req_stall);
      sb.note_constraint(w);
   endtask

   // write the cable length once the core has drained
   task automatic write_length(bit [30:0] len);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.displacement_queue.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
      csr_valid <= 1'b1;
      csr_cable_length <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.cable_length = len;
   endtask

   function bit [31:0] rand_mass();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hffffffff;
         2: return $urandom_range(1, 16) << 16;
         default: return $urandom;
      endcase
   endfunction

   // random word: mostly near the cable length, some anywhere, some extreme
   function constraint_type rand_word(bit [30:0] len);
      constraint_type w;
      int sel;
      int span;
      sel = $urandom_range(0, 9);
      w.is_point = 1'($urandom_range(0, 1));
      w.ia = rand_mass();
      w.ib = rand_mass();
      w.ax = $urandom;
      w.ay = $urandom;
      w.az = $urandom;
      if (sel < 6) begin
         span = (len > 31'h3fffffff) ? 32'h7fffffff : 2 * len + 32'h10000;
         w.px = w.ax + $signed($urandom_range(0, span)) - span / 2;
         w.py = w.ay + $signed($urandom_range(0, span)) - span / 2;
         w.pz = w.az + $signed($urandom_range(0, span)) - span / 2;
      end else if (sel < 9) begin
         w.px = $urandom;
         w.py = $urandom;
         w.pz = $urandom;
      end else begin
         w.ax = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         w.px = ~w.ax;
         w.py = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         w.pz = $urandom;
      end
      return w;
   endfunction

   function constraint_type make_word(bit pt, int ax, int ay, int az, bit [31:0] ia,
                                      int px, int py, int pz, bit [31:0] ib);
      constraint_type w;
      w.is_point = pt;
      w.ax = ax; w.ay = ay; w.az = az; w.ia = ia;
      w.px = px; w.py = py; w.pz = pz; w.ib = ib;
      return w;
   endfunction

   localparam int MAXP = 32'h7fffffff;
   localparam int MAXN = 32'h80000000;

   initial begin
      bit [30:0] lengths[6];
      sb = new();
      quiet = 0;
      hold_request = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_anchor_is_point = 1'b0;
      {req_anchor_x, req_anchor_y, req_anchor_z, req_anchor_inv_mass} = '0;
      {req_particle_x, req_particle_y, req_particle_z, req_particle_inv_mass} = '0;
      csr_valid = 1'b0;
      csr_cable_length = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset length, then at lengths zero and maximum
      send_word(make_word(0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));        // zero vector
      send_word(make_word(0, 32'h8000, 0, 0, 32'h10000, 0, 0, 0, 32'h10000)); // slack
      send_word(make_word(0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, 1));       // exactly length
      send_word(make_word(0, 32'h30000, 32'h40000, 0, 32'h10000, 0, 0, 0, 32'h30000));
      send_word(make_word(1, 32'h30000, 32'h40000, 0, 32'h10000, 0, 0, 0, 32'h30000));
      send_word(make_word(0, -32'h30000, 32'h40000, -32'h5000, 0, 0, 0, 0, 32'h20000));
      send_word(make_word(0, 32'h50000, -32'h20000, 32'h7000, 32'h8000, 0, 0, 0, 0));
      send_word(make_word(0, 32'h50000, 32'h20000, 32'h7000, 0, 0, 0, 0, 0));
      send_word(make_word(0, MAXP, MAXP, MAXP, ~32'h0, MAXN, MAXN, MAXN, ~32'h0));
      send_word(make_word(1, MAXN, MAXN, MAXN, 0, MAXP, MAXP, MAXP, ~32'h0));
      send_word(make_word(0, MAXP, MAXN, MAXP, ~32'h0, MAXN, MAXP, MAXN, 0));
      send_word(make_word(0, MAXN, MAXP, 0, 1, MAXP, MAXN, 0, ~32'h0));
      send_word(make_word(0, MAXP, 0, 0, ~32'h0, MAXN, 0, 0, 1));
      send_word(make_word(1, 0, 0, MAXN, 32'h10000, 0, 0, MAXP, 0));
      write_length(31'd0);
      send_word(make_word(0, 1, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
      send_word(make_word(0, 0, -1, 0, 1, 0, 0, 0, ~32'h0));
      send_word(make_word(0, MAXP, MAXP, MAXP, ~32'h0, MAXN, MAXN, MAXN, 1));
      write_length(31'h7fffffff);
      send_word(make_word(0, MAXP, MAXP, MAXP, ~32'h0, MAXN, MAXN, MAXN, ~32'h0));
      send_word(make_word(1, MAXP, MAXP, 0, 0, MAXN, MAXN, 0, 1));

      // random phases over several lengths, one with a long result hold-off
      lengths[0] = 31'd65536;
      lengths[1] = 31'd0;
      lengths[2] = 31'h7fffffff;
      lengths[3] = 31'h00100000;
      lengths[4] = 31'($urandom);
      lengths[5] = 31'($urandom_range(1, 32'h40000));
      for (int p = 0; p < 6; p++) begin
         write_length(lengths[p]);
         quiet = (p == 3);
         if (p == 1) hold_request = 1;
         for (int i = 0; i < 140; i++) send_word(rand_word(lengths[p]));
      end
      quiet = 0;
      req_valid <= 1'b0;

      // drain
      while (sb.displacement_queue.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (sb.errors == 0 && sb.displacement_queue.size() == 0) begin
         $display("cable_constraint_projection_core regression: pass");
      end else begin
         $display("cable_constraint_projection_core regression: fail");
      end
      $finish;
   end
endmodule
